>>> rtl/sin2_pulse_field_generator_assert.svh
// ----------------------------------------------------------------------------
// sin2 pulse field generator assertion macros
// Shared concurrent assertion forms, clocked on the rising edge and
// disabled while the active-low reset is asserted.
// ----------------------------------------------------------------------------
`ifndef SIN2_PULSE_FIELD_GENERATOR_ASSERT_SVH
`define SIN2_PULSE_FIELD_GENERATOR_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define SPFG_ASSERT_IMP(lbl, ck, rstn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("spfg assertion failed");

// antecedent implies consequent in the next cycle
`define SPFG_ASSERT_NXT(lbl, ck, rstn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("spfg assertion failed");

`endif

>>> rtl/spfg_pkg.sv
// ----------------------------------------------------------------------------
// spfg_pkg
// Constants, types and helper functions of the sin2 pulse field generator.
// ----------------------------------------------------------------------------
package spfg_pkg;

	localparam int unsigned TRIG_ITER_DEF = 20;
	localparam int unsigned TRIG_ITER_MAX = 32;

	localparam int unsigned CORDIC_W   = 34;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 54;
	localparam int unsigned RS_W       = 40;
	localparam int unsigned PRODC_W    = 65;

	localparam logic [31:0] PI_Q30 = 32'd3373259426;
	localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sd652032874;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_DELAY     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CAR_RATE  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ENV_RATE  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FIELD_AMP = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_POT_AMP   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_MAJOR     = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_MINOR     = 3'd7;

	// phase quadrants
	localparam logic [1:0] QUAD_I   = 2'd0;
	localparam logic [1:0] QUAD_II  = 2'd1;
	localparam logic [1:0] QUAD_III = 2'd2;
	localparam logic [1:0] QUAD_IV  = 2'd3;

	typedef struct packed {
		logic [31:0] field_amp;
		logic [31:0] potential_amp;
		logic [53:0] major_vector;
		logic [53:0] minor_vector;
		logic [39:0] env_slope;
	} mix_cfg_t;

	// atan(2^-i) in Q0.30, truncated
	function automatic logic [29:0] atan_q30(input logic [4:0] i);
		logic [29:0] r;
		unique case (i)
			5'd0:  r = 30'd843314856;
			5'd1:  r = 30'd497837829;
			5'd2:  r = 30'd263043836;
			5'd3:  r = 30'd133525158;
			5'd4:  r = 30'd67021686;
			5'd5:  r = 30'd33543515;
			5'd6:  r = 30'd16775850;
			5'd7:  r = 30'd8388437;
			5'd8:  r = 30'd4194282;
			5'd9:  r = 30'd2097149;
			5'd10: r = 30'd1048575;
			5'd11: r = 30'd524287;
			5'd12: r = 30'd262143;
			5'd13: r = 30'd131071;
			5'd14: r = 30'd65535;
			5'd15: r = 30'd32767;
			5'd16: r = 30'd16383;
			5'd17: r = 30'd8191;
			5'd18: r = 30'd4095;
			5'd19: r = 30'd2047;
			5'd20: r = 30'd1023;
			5'd21: r = 30'd511;
			5'd22: r = 30'd255;
			5'd23: r = 30'd127;
			5'd24: r = 30'd63;
			5'd25: r = 30'd31;
			5'd26: r = 30'd15;
			5'd27: r = 30'd7;
			5'd28: r = 30'd3;
			5'd29: r = 30'd1;
			5'd30: r = 30'd0;
			5'd31: r = 30'd0;
		endcase
		return r;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [40:0] v);
		logic signed [31:0] r;
		if (v > 41'sd2147483647)
			r = 32'sh7fffffff;
		else if (v < -41'sd2147483648)
			r = 32'sh80000000;
		else
			r = v[31:0];
		return r;
	endfunction

endpackage

>>> rtl/spfg_if.sv
// ----------------------------------------------------------------------------
// spfg channel interfaces
// Valid/ready channels for samples, results and register writes.
// ----------------------------------------------------------------------------
interface spfg_in_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] sample_time;
	modport source(output valid, output sample_time, input ready);
	modport sink(input valid, input sample_time, output ready);
endinterface

interface spfg_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] pot_x;
	logic signed [31:0] pot_y;
	logic signed [31:0] pot_z;
	logic signed [31:0] field_x;
	logic signed [31:0] field_y;
	logic signed [31:0] field_z;
	modport source(output valid, output pot_x, output pot_y, output pot_z,
		output field_x, output field_y, output field_z, input ready);
	modport sink(input valid, input pot_x, input pot_y, input pot_z,
		input field_x, input field_y, input field_z, output ready);
endinterface

interface spfg_cfg_if import spfg_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

>>> rtl/spfg_cordic.sv
// ----------------------------------------------------------------------------
// spfg_cordic
// Pipelined rotation CORDIC: sine and cosine of a Q0.32 turn phase, Q2.30.
// One stage converts to radians, one stage per iteration, one quadrant stage.
// ----------------------------------------------------------------------------
module spfg_cordic import spfg_pkg::*; #(
	parameter int unsigned ITERATIONS = TRIG_ITER_DEF
) (
	input  logic               clk,
	input  logic               en,
	input  logic [31:0]        phase,
	output logic signed [31:0] sin_val,
	output logic signed [31:0] cos_val
);

	localparam int unsigned NI = (ITERATIONS > TRIG_ITER_MAX) ? TRIG_ITER_MAX : ITERATIONS;

	logic signed [CORDIC_W-1:0] x_s [NI+1];
	logic signed [CORDIC_W-1:0] y_s [NI+1];
	logic signed [CORDIC_W-1:0] z_s [NI+1];
	logic [1:0]                 quad_s [NI+1];
	logic [62:0]                zprod;

	// fraction of a quadrant to radians, rounded
	assign zprod = {33'd0, phase[29:0]} * {31'd0, PI_Q30} + 63'd1073741824;

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0]    <= CORDIC_GAIN;
			y_s[0]    <= '0;
			z_s[0]    <= $signed({(CORDIC_W-31)'(0), zprod[61:31]});
			quad_s[0] <= phase[31:30];
		end
	end

	for (genvar i = 0; i < NI; i++) begin : g_iter
		logic signed [CORDIC_W-1:0] dx;
		logic signed [CORDIC_W-1:0] dy;
		logic signed [CORDIC_W-1:0] da;

		assign dx = y_s[i] >>> i;
		assign dy = x_s[i] >>> i;
		assign da = $signed({(CORDIC_W-30)'(0), atan_q30(5'(i))});

		always_ff @(posedge clk) begin
			if (en) begin
				if (!z_s[i][CORDIC_W-1]) begin
					x_s[i+1] <= x_s[i] - dx;
					y_s[i+1] <= y_s[i] + dy;
					z_s[i+1] <= z_s[i] - da;
				end else begin
					x_s[i+1] <= x_s[i] + dx;
					y_s[i+1] <= y_s[i] - dy;
					z_s[i+1] <= z_s[i] + da;
				end
				quad_s[i+1] <= quad_s[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			unique case (quad_s[NI])
				QUAD_I: begin
					sin_val <= 32'(y_s[NI]);
					cos_val <= 32'(x_s[NI]);
				end
				QUAD_II: begin
					sin_val <= 32'(x_s[NI]);
					cos_val <= 32'(-y_s[NI]);
				end
				QUAD_III: begin
					sin_val <= 32'(-y_s[NI]);
					cos_val <= 32'(-x_s[NI]);
				end
				QUAD_IV: begin
					sin_val <= 32'(-x_s[NI]);
					cos_val <= 32'(y_s[NI]);
				end
			endcase
		end
	end

endmodule

>>> rtl/spfg_mix.sv
// ----------------------------------------------------------------------------
// spfg_mix
// Five-stage arithmetic pipeline: envelope terms, polarization projections,
// slope term with saturation, and the split products for each component.
// ----------------------------------------------------------------------------
module spfg_mix import spfg_pkg::*; (
	input  logic                      clk,
	input  logic                      en,
	input  mix_cfg_t                  cfg,
	input  logic signed [31:0]        env_sin,
	input  logic signed [31:0]        env_cos,
	input  logic signed [31:0]        car_sin,
	input  logic signed [31:0]        car_cos,
	output logic signed [RS_W-1:0]    pot [3],
	output logic signed [RS_W-1:0]    fld_base [3],
	output logic signed [PRODC_W-1:0] slope_prod [3]
);

	// stage 1: s^2 and s*c
	logic signed [63:0] ss_p;
	logic signed [63:0] sc_p;
	logic signed [32:0] s2_s1;
	logic signed [32:0] sc_s1;

	assign ss_p = env_sin * env_sin;
	assign sc_p = env_sin * env_cos;

	always_ff @(posedge clk) begin
		if (en) begin
			s2_s1 <= 33'((ss_p + 64'sd536870912) >>> 30);
			sc_s1 <= 33'((sc_p + 64'sd536870912) >>> 30);
		end
	end

	// stage 2: amplitude times envelope
	logic signed [32:0] amp_pot;
	logic signed [32:0] amp_fld;
	logic signed [65:0] ea_p;
	logic signed [65:0] e1_p;
	logic signed [65:0] g_p;
	logic signed [33:0] env_a_s2;
	logic signed [33:0] env1_s2;
	logic signed [33:0] g_s2;

	assign amp_pot = $signed({1'b0, cfg.potential_amp});
	assign amp_fld = $signed({1'b0, cfg.field_amp});
	assign ea_p    = amp_pot * s2_s1;
	assign e1_p    = amp_fld * s2_s1;
	assign g_p     = amp_pot * sc_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			env_a_s2 <= 34'((ea_p + 66'sd536870912) >>> 30);
			env1_s2  <= 34'((e1_p + 66'sd536870912) >>> 30);
			g_s2     <= 34'((g_p + 66'sd536870912) >>> 30);
		end
	end

	// stage 3: |g| times slope, in two halves of the slope
	logic [33:0] mag_c;
	logic [53:0] sl_lo;
	logic [53:0] sl_hi;
	logic [53:0] sl_lo_s3;
	logic [53:0] sl_hi_s3;
	logic        gneg_s3;

	assign mag_c = g_s2[33] ? 34'(-g_s2) : 34'(g_s2);
	assign sl_lo = mag_c * cfg.env_slope[19:0];
	assign sl_hi = mag_c * cfg.env_slope[39:20];

	always_ff @(posedge clk) begin
		if (en) begin
			sl_lo_s3 <= sl_lo;
			sl_hi_s3 <= sl_hi;
			gneg_s3  <= g_s2[33];
		end
	end

	// stage 4: slope term, saturated to a 31-bit magnitude
	logic [73:0]        sp;
	logic [48:0]        sm;
	logic [30:0]        smag;
	logic signed [31:0] env2_s4;

	assign sp   = {sl_hi_s3, 20'd0} + {20'd0, sl_lo_s3};
	assign sm   = 49'((sp + 74'd16777216) >> 25);
	assign smag = (sm > 49'd2147483647) ? 31'h7fffffff : sm[30:0];

	always_ff @(posedge clk) begin
		if (en) begin
			env2_s4 <= gneg_s3 ? -$signed({1'b0, smag}) : $signed({1'b0, smag});
		end
	end

	for (genvar k = 0; k < 3; k++) begin : g_comp
		logic signed [17:0]        maj;
		logic signed [17:0]        mnr;
		logic signed [50:0]        a1;
		logic signed [50:0]        a2;
		logic signed [32:0]        p1_s1;
		logic signed [32:0]        p2_s1;
		logic signed [32:0]        p1_s2;
		logic signed [32:0]        p2_s2;
		logic signed [51:0]        pa_lo;
		logic signed [49:0]        pa_hi;
		logic signed [51:0]        pb_lo;
		logic signed [49:0]        pb_hi;
		logic signed [51:0]        pa_lo_s3;
		logic signed [49:0]        pa_hi_s3;
		logic signed [51:0]        pb_lo_s3;
		logic signed [49:0]        pb_hi_s3;
		logic signed [32:0]        p2_s3;
		logic signed [67:0]        pa_sum;
		logic signed [67:0]        pb_sum;
		logic signed [RS_W-1:0]    pot_s4;
		logic signed [RS_W-1:0]    f1_s4;
		logic signed [32:0]        p2_s4;
		logic signed [PRODC_W-1:0] pc;
		logic signed [RS_W-1:0]    pot_s5;
		logic signed [RS_W-1:0]    f1_s5;
		logic signed [PRODC_W-1:0] pc_s5;

		assign maj = $signed(cfg.major_vector[18*k +: 18]);
		assign mnr = $signed(cfg.minor_vector[18*k +: 18]);
		assign a1  = car_cos * maj + car_sin * mnr;
		assign a2  = car_sin * maj - car_cos * mnr;

		// operands split at bit 17 to keep the multipliers narrow
		assign pa_lo = env_a_s2 * $signed({1'b0, p2_s2[16:0]});
		assign pa_hi = env_a_s2 * $signed(p2_s2[32:17]);
		assign pb_lo = env1_s2 * $signed({1'b0, p1_s2[16:0]});
		assign pb_hi = env1_s2 * $signed(p1_s2[32:17]);

		assign pa_sum = (68'(pa_hi_s3) <<< 17) + 68'(pa_lo_s3);
		assign pb_sum = (68'(pb_hi_s3) <<< 17) + 68'(pb_lo_s3);

		assign pc = env2_s4 * p2_s4;

		always_ff @(posedge clk) begin
			if (en) begin
				p1_s1    <= 33'((a1 + 51'sd131072) >>> 18);
				p2_s1    <= 33'((a2 + 51'sd131072) >>> 18);
				p1_s2    <= p1_s1;
				p2_s2    <= p2_s1;
				pa_lo_s3 <= pa_lo;
				pa_hi_s3 <= pa_hi;
				pb_lo_s3 <= pb_lo;
				pb_hi_s3 <= pb_hi;
				p2_s3    <= p2_s2;
				pot_s4   <= RS_W'(-((pa_sum + 68'sd134217728) >>> 28));
				f1_s4    <= RS_W'((pb_sum + 68'sd134217728) >>> 28);
				p2_s4    <= p2_s3;
				pot_s5   <= pot_s4;
				f1_s5    <= f1_s4;
				pc_s5    <= pc;
			end
		end

		assign pot[k]        = pot_s5;
		assign fld_base[k]   = f1_s5;
		assign slope_prod[k] = pc_s5;
	end

endmodule

>>> rtl/sin2_pulse_field_generator.sv
// ----------------------------------------------------------------------------
// sin2_pulse_field_generator
// Vector potential and electric field of a sin^2-envelope pulse, evaluated
// for one time sample per item.
// ----------------------------------------------------------------------------
//  channel  dir  payload                                 accepted when
//  sample   in   sample_time                             valid && ready
//  result   out  pot_x..z, field_x..z                    valid && ready
//  cfg      in   index, data                             valid && ready
//
// one item per cycle while result is taken; the two cordic pipelines have
// one stage per iteration
// a stalled result holds the whole pipeline, nothing is dropped or repeated
// arst_n clears the cfg-written registers and the valid bits; cfg.ready is always high
// ----------------------------------------------------------------------------
`include "sin2_pulse_field_generator_assert.svh"

module sin2_pulse_field_generator import spfg_pkg::*; #(
	parameter int unsigned TRIG_ITERATIONS = TRIG_ITER_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	spfg_in_if.sink      sample,
	spfg_out_if.source   result,
	spfg_cfg_if.sink     cfg
);

	localparam int unsigned NI    = (TRIG_ITERATIONS > TRIG_ITER_MAX) ?
		TRIG_ITER_MAX : TRIG_ITERATIONS;
	localparam int unsigned DEPTH = NI + 9;

	// configuration registers
	logic signed [31:0] delay_q;
	logic signed [31:0] offset_q;
	logic [31:0]        car_rate_q;
	logic [31:0]        env_rate_q;
	logic [31:0]        field_amp_q;
	logic [31:0]        pot_amp_q;
	logic [53:0]        major_q;
	logic [53:0]        minor_q;
	logic [39:0]        slope_q;
	logic [63:0]        rprod;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q     <= '0;
			offset_q    <= '0;
			car_rate_q  <= '0;
			env_rate_q  <= '0;
			field_amp_q <= '0;
			pot_amp_q   <= '0;
			major_q     <= '0;
			minor_q     <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_DELAY:     delay_q     <= cfg.data[31:0];
				REG_OFFSET:    offset_q    <= cfg.data[31:0];
				REG_CAR_RATE:  car_rate_q  <= cfg.data[31:0];
				REG_ENV_RATE:  env_rate_q  <= cfg.data[31:0];
				REG_FIELD_AMP: field_amp_q <= cfg.data[31:0];
				REG_POT_AMP:   pot_amp_q   <= cfg.data[31:0];
				REG_MAJOR:     major_q     <= cfg.data;
				REG_MINOR:     minor_q     <= cfg.data;
			endcase
		end
	end

	// envelope angular rate in Q26, follows the envelope rate register
	assign rprod = 64'(env_rate_q) * 64'(PI_Q30);

	always_ff @(posedge clk) begin
		slope_q <= 40'((rprod + 64'd8388608) >> 24);
	end

	// pipeline control
	logic             en;
	logic             out_vld_q;
	logic [DEPTH-1:0] vld_q;
	logic [DEPTH-1:0] zero_q;

	assign en           = !out_vld_q || result.ready;
	assign sample.ready = en;

	// stage 1: shifted time, before-delay flag
	logic signed [33:0] ts_c;
	logic               before_c;
	logic [32:0]        ts_s1;

	assign ts_c     = 34'(sample.sample_time) - 34'(delay_q) + 34'(offset_q);
	assign before_c = sample.sample_time < delay_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else if (en)
			vld_q <= {vld_q[DEPTH-2:0], sample.valid};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			zero_q <= {zero_q[DEPTH-2:0], before_c};
			ts_s1  <= ts_c[32:0];
		end
	end

	// stage 2: phases in turns
	logic [32:0] ep_c;
	logic [31:0] cp_c;
	logic [31:0] env_ph_s2;
	logic [31:0] car_ph_s2;

	assign ep_c = ts_s1 * {1'b0, env_rate_q};
	assign cp_c = ts_s1[31:0] * car_rate_q;

	always_ff @(posedge clk) begin
		if (en) begin
			env_ph_s2 <= ep_c[32:1];
			car_ph_s2 <= cp_c;
		end
	end

	logic signed [31:0] env_sin;
	logic signed [31:0] env_cos;
	logic signed [31:0] car_sin;
	logic signed [31:0] car_cos;

	spfg_cordic #(.ITERATIONS(TRIG_ITERATIONS)) u_env_cordic (
		.clk     (clk),
		.en      (en),
		.phase   (env_ph_s2),
		.sin_val (env_sin),
		.cos_val (env_cos)
	);

	spfg_cordic #(.ITERATIONS(TRIG_ITERATIONS)) u_car_cordic (
		.clk     (clk),
		.en      (en),
		.phase   (car_ph_s2),
		.sin_val (car_sin),
		.cos_val (car_cos)
	);

	mix_cfg_t                  mcfg;
	logic signed [RS_W-1:0]    pot [3];
	logic signed [RS_W-1:0]    fld_base [3];
	logic signed [PRODC_W-1:0] slope_prod [3];

	assign mcfg = '{field_amp: field_amp_q, potential_amp: pot_amp_q,
		major_vector: major_q, minor_vector: minor_q, env_slope: slope_q};

	spfg_mix u_mix (
		.clk        (clk),
		.en         (en),
		.cfg        (mcfg),
		.env_sin    (env_sin),
		.env_cos    (env_cos),
		.car_sin    (car_sin),
		.car_cos    (car_cos),
		.pot        (pot),
		.fld_base   (fld_base),
		.slope_prod (slope_prod)
	);

	// output register: final rounding, sum, saturation and zeroing before the delay
	logic signed [31:0] pot_q [3];
	logic signed [31:0] fld_q [3];

	for (genvar k = 0; k < 3; k++) begin : g_out
		logic signed [36:0] slope_c;
		logic signed [40:0] fsum;

		assign slope_c = 37'((slope_prod[k] + 65'sd134217728) >>> 28);
		assign fsum    = 41'(fld_base[k]) + 41'(slope_c);

		always_ff @(posedge clk) begin
			if (en) begin
				pot_q[k] <= zero_q[DEPTH-1] ? '0 : sat32(41'(pot[k]));
				fld_q[k] <= zero_q[DEPTH-1] ? '0 : sat32(fsum);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_vld_q <= 1'b0;
		else if (en)
			out_vld_q <= vld_q[DEPTH-1];
	end

	assign result.valid   = out_vld_q;
	assign result.pot_x   = pot_q[0];
	assign result.pot_y   = pot_q[1];
	assign result.pot_z   = pot_q[2];
	assign result.field_x = fld_q[0];
	assign result.field_y = fld_q[1];
	assign result.field_z = fld_q[2];

	`SPFG_ASSERT_NXT(a_accept_fills_s1, clk, arst_n, sample.valid && sample.ready, vld_q[0])
	`SPFG_ASSERT_IMP(a_stall_blocks_in, clk, arst_n, result.valid && !result.ready, !sample.ready)
	`SPFG_ASSERT_NXT(a_zero_before_delay, clk, arst_n, vld_q[DEPTH-1] && zero_q[DEPTH-1] && en, result.valid && result.pot_x == 0 && result.field_z == 0)

endmodule
